@@ hdl/uifp_pkg.sv @@
// Shared types, codes and defaults for the UART receive FIFO packetizer.
package uifp_pkg;

   localparam int RING_DEPTH_DEF   = 64;
   localparam int PACKET_DEPTH_DEF = 128;

   localparam logic [7:0] IDLE_LIMIT_RESET = 8'd5;
   localparam logic [7:0] IDLE_TICKS_MAX   = 8'hFF;
   localparam logic [7:0] BYTE_ZERO        = 8'h00;

   // request commands
   localparam logic [2:0] CMD_RX_BYTE = 3'd0;
   localparam logic [2:0] CMD_DRAIN   = 3'd1;
   localparam logic [2:0] CMD_TICK    = 3'd2;
   localparam logic [2:0] CMD_READ    = 3'd3;
   localparam logic [2:0] CMD_CLEAR   = 3'd4;

   // result status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_FIFO_FULL  = 2'd1;
   localparam logic [1:0] ST_FIFO_EMPTY = 2'd2;
   localparam logic [1:0] ST_PKT_FULL   = 2'd3;

   // where the result byte comes from
   typedef enum logic [1:0] {
      SRC_NONE = 2'd0,
      SRC_RING = 2'd1,
      SRC_PKT  = 2'd2
   } src_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] rx_data;
      logic [6:0] read_index;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic [1:0] status;
      logic [7:0] packet_length;
      logic       packet_done;
      logic       fetch_active;
      logic [5:0] fifo_count;
   } rsp_type;

   // everything the result needs except the byte itself
   typedef struct packed {
      logic       pkt_wr;
      logic       byte_valid;
      src_type    src;
      logic [1:0] status;
      logic [7:0] packet_length;
      logic       packet_done;
      logic       fetch_active;
      logic [5:0] fifo_count;
   } meta_type;

endpackage

@@ hdl/uart_rx_fifo_idle_packetizer_top.sv @@
// Top level of the UART receive FIFO with idle-timeout packet framing.
// A result passes through stage 1 and then the output register after acceptance.
// Throughput: one request per cycle unless the output stalls; one access per memory.
// A drained byte is written to the packet memory from stage 1, forwarded to reads.
// Reset is synchronous, clears pointers, counts, timer and pipeline; no memory sweep.
module uart_rx_fifo_idle_packetizer_top #(
   parameter int RING_DEPTH   = uifp_pkg::RING_DEPTH_DEF,
   parameter int PACKET_DEPTH = uifp_pkg::PACKET_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  uifp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output uifp_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [7:0]        csr_write_data
);

   localparam int RP_W = $clog2(RING_DEPTH);
   localparam int PA_W = (PACKET_DEPTH > 1) ? $clog2(PACKET_DEPTH) : 1;

   // idle limit register
   logic [7:0] idle_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_limit_ff <= uifp_pkg::IDLE_LIMIT_RESET;
      end else if (csr_write_enable) begin
         idle_limit_ff <= csr_write_data;
      end
   end

   // Handshake: stage 1 holds the decoded request while memory reads complete,
   // the output register holds the finished result. Stage 1 only stalls
   // when the output register is full and not being taken.
   logic accept, out_ready, s1_adv;
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && out_ready;
   assign req_stall = s1_valid_ff && !out_ready;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_adv ? 1'b1 : (out_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // State update happens at acceptance; memory reads are issued the same edge.
   logic               ring_wr_en, ring_rd_en, pkt_rd_en, pkt_wr_en;
   logic [RP_W-1:0]    ring_wr_addr, ring_rd_addr;
   logic [PA_W-1:0]    pkt_rd_addr, pkt_wr_addr;
   logic [7:0]         ring_rd_data, pkt_rd_data;
   uifp_pkg::meta_type meta;

   uifp_ctrl #(
      .RING_DEPTH   (RING_DEPTH),
      .PACKET_DEPTH (PACKET_DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req          (req_data),
      .idle_limit   (idle_limit_ff),
      .ring_wr_en   (ring_wr_en),
      .ring_wr_addr (ring_wr_addr),
      .ring_rd_en   (ring_rd_en),
      .ring_rd_addr (ring_rd_addr),
      .pkt_rd_en    (pkt_rd_en),
      .pkt_rd_addr  (pkt_rd_addr),
      .pkt_wr_addr  (pkt_wr_addr),
      .meta         (meta)
   );

   uifp_ring_mem #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring_mem (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (ring_wr_addr),
      .wr_data (req_data.rx_data),
      .rd_en   (ring_rd_en),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_data)
   );

   // stage 1 payload
   uifp_pkg::meta_type s1_meta_ff;
   logic [PA_W-1:0]    s1_pkt_addr_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff     <= meta;
         s1_pkt_addr_ff <= pkt_wr_addr;
      end
   end

   // The drained byte is stored while its request sits in stage 1. A repeated
   // write during a stall carries the same address and data.
   assign pkt_wr_en = s1_valid_ff && s1_meta_ff.pkt_wr;

   uifp_pkt_mem #(
      .PACKET_DEPTH (PACKET_DEPTH)
   ) u_pkt_mem (
      .clock   (clock),
      .wr_en   (pkt_wr_en),
      .wr_addr (s1_pkt_addr_ff),
      .wr_data (ring_rd_data),
      .rd_en   (pkt_rd_en),
      .rd_addr (pkt_rd_addr),
      .rd_data (pkt_rd_data)
   );

   // output register
   uifp_pkg::rsp_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in.byte_valid    = s1_meta_ff.byte_valid;
      rsp_in.status        = s1_meta_ff.status;
      rsp_in.packet_length = s1_meta_ff.packet_length;
      rsp_in.packet_done   = s1_meta_ff.packet_done;
      rsp_in.fetch_active  = s1_meta_ff.fetch_active;
      rsp_in.fifo_count    = s1_meta_ff.fifo_count;
      case (s1_meta_ff.src)
         uifp_pkg::SRC_RING: rsp_in.out_byte = ring_rd_data;
         uifp_pkg::SRC_PKT:  rsp_in.out_byte = pkt_rd_data;
         default:            rsp_in.out_byte = uifp_pkg::BYTE_ZERO;
      endcase
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_stall_needs_s1: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("request stalled with stage 1 empty");

   a_pkt_wr_needs_s1: assert property (@(posedge clock) disable iff (reset)
      s1_meta_ff.pkt_wr && !s1_valid_ff |=> !pkt_wr_en || s1_valid_ff)
      else $error("packet write issued without a request in stage 1");

   a_empty_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status == uifp_pkg::ST_FIFO_EMPTY) |-> !rsp_ff.byte_valid)
      else $error("empty FIFO drain reported a byte");

   a_done_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.packet_done |-> !rsp_ff.fetch_active)
      else $error("packet done while still gathering");

   a_s1_moves: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("stage 1 advanced but no result registered");
`endif

endmodule

@@ hdl/uifp_ring_mem.sv @@
// Ring FIFO byte storage: one write port, one registered read port.
module uifp_ring_mem #(
   parameter int RING_DEPTH = uifp_pkg::RING_DEPTH_DEF,
   localparam int RP_W = $clog2(RING_DEPTH)
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [RP_W-1:0] wr_addr,
   input  logic [7:0]      wr_data,
   input  logic            rd_en,
   input  logic [RP_W-1:0] rd_addr,
   output logic [7:0]      rd_data
);

   logic [7:0] mem [RING_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/uifp_pkt_mem.sv @@
// Packet byte storage with write-to-read forwarding on a same-address read.
module uifp_pkt_mem #(
   parameter int PACKET_DEPTH = uifp_pkg::PACKET_DEPTH_DEF,
   localparam int PA_W = (PACKET_DEPTH > 1) ? $clog2(PACKET_DEPTH) : 1
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [PA_W-1:0] wr_addr,
   input  logic [7:0]      wr_data,
   input  logic            rd_en,
   input  logic [PA_W-1:0] rd_addr,
   output logic [7:0]      rd_data
);

   logic [7:0] mem [PACKET_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // write lands this edge: forward it
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/uifp_ctrl.sv @@
// Pointer, packet count and idle timer state with per-request decode.
module uifp_ctrl #(
   parameter int RING_DEPTH   = uifp_pkg::RING_DEPTH_DEF,
   parameter int PACKET_DEPTH = uifp_pkg::PACKET_DEPTH_DEF,
   localparam int RP_W = $clog2(RING_DEPTH),
   localparam int PA_W = (PACKET_DEPTH > 1) ? $clog2(PACKET_DEPTH) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  uifp_pkg::req_type  req,
   input  logic [7:0]         idle_limit,
   output logic               ring_wr_en,
   output logic [RP_W-1:0]    ring_wr_addr,
   output logic               ring_rd_en,
   output logic [RP_W-1:0]    ring_rd_addr,
   output logic               pkt_rd_en,
   output logic [PA_W-1:0]    pkt_rd_addr,
   output logic [PA_W-1:0]    pkt_wr_addr,
   output uifp_pkg::meta_type meta
);

   localparam int PC_W  = $clog2(PACKET_DEPTH + 1);
   localparam int FC_W  = (RP_W + 1 > 6) ? RP_W + 1 : 6;
   localparam int PL_W  = (PC_W > 8) ? PC_W : 8;
   localparam int CMP_W = (PC_W > 7) ? PC_W : 7;
   localparam int RA_W  = (PA_W > 7) ? PA_W : 7;

   logic [RP_W-1:0] wp_ff, wp_in, rp_ff, rp_in, wp_nxt, rp_nxt;
   logic [PC_W-1:0] count_ff, count_in;
   logic [7:0]      idle_ff, idle_in, idle_sat;
   logic            gath_ff, gath_in;
   logic            empty, full, ring_wr, ring_rd, pkt_rd;
   logic [RP_W:0]   fill;
   logic [FC_W-1:0] fill_ext;
   logic [PL_W-1:0] count_ext;
   logic [CMP_W-1:0] ridx_cmp, count_cmp;
   logic [RA_W-1:0] ridx_addr;

   assign wp_nxt = (wp_ff == RP_W'(RING_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign rp_nxt = (rp_ff == RP_W'(RING_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
   assign empty  = (wp_ff == rp_ff);
   assign full   = (wp_nxt == rp_ff);
   assign idle_sat = (idle_ff == uifp_pkg::IDLE_TICKS_MAX) ? idle_ff : idle_ff + 8'd1;

   assign ridx_cmp  = CMP_W'(req.read_index);
   assign count_cmp = CMP_W'(count_ff);
   assign ridx_addr = RA_W'(req.read_index);

   always_comb begin
      wp_in    = wp_ff;
      rp_in    = rp_ff;
      count_in = count_ff;
      idle_in  = idle_ff;
      gath_in  = gath_ff;
      ring_wr  = 1'b0;
      ring_rd  = 1'b0;
      pkt_rd   = 1'b0;
      meta     = '0;
      meta.src = uifp_pkg::SRC_NONE;
      meta.status = uifp_pkg::ST_OK;
      case (req.cmd)
         uifp_pkg::CMD_RX_BYTE: begin
            if (full) begin
               meta.status = uifp_pkg::ST_FIFO_FULL;
            end else begin
               ring_wr = 1'b1;
               wp_in   = wp_nxt;
            end
         end
         uifp_pkg::CMD_DRAIN: begin
            if (empty) begin
               meta.status = uifp_pkg::ST_FIFO_EMPTY;
            end else begin
               ring_rd         = 1'b1;
               rp_in           = rp_nxt;
               meta.byte_valid = 1'b1;
               meta.src        = uifp_pkg::SRC_RING;
               if (count_ff < PC_W'(PACKET_DEPTH)) begin
                  meta.pkt_wr = 1'b1;
                  count_in    = count_ff + 1'b1;
               end else begin
                  meta.status = uifp_pkg::ST_PKT_FULL;
               end
               gath_in = 1'b1;
               idle_in = '0;
            end
         end
         uifp_pkg::CMD_TICK: begin
            if (gath_ff && empty) begin
               if (idle_sat >= idle_limit) begin
                  meta.packet_done = 1'b1;
                  gath_in = 1'b0;
                  idle_in = '0;
               end else begin
                  idle_in = idle_sat;
               end
            end
         end
         uifp_pkg::CMD_READ: begin
            // inside the store but past the length: valid, reads as zero
            if (ridx_cmp < CMP_W'(PACKET_DEPTH)) begin
               meta.byte_valid = 1'b1;
               if (ridx_cmp < count_cmp) begin
                  pkt_rd   = 1'b1;
                  meta.src = uifp_pkg::SRC_PKT;
               end
            end
         end
         uifp_pkg::CMD_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
      fill = (wp_in >= rp_in) ? ({1'b0, wp_in} - {1'b0, rp_in})
                              : ({1'b0, wp_in} + (RP_W+1)'(RING_DEPTH) - {1'b0, rp_in});
      fill_ext  = FC_W'(fill);
      count_ext = PL_W'(count_in);
      meta.fifo_count    = fill_ext[5:0];
      meta.packet_length = count_ext[7:0];
      meta.fetch_active  = gath_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
         idle_ff  <= '0;
         gath_ff  <= 1'b0;
      end else if (accept) begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
         idle_ff  <= idle_in;
         gath_ff  <= gath_in;
      end
   end

   assign ring_wr_en   = accept & ring_wr;
   assign ring_wr_addr = wp_ff;
   assign ring_rd_en   = accept & ring_rd;
   assign ring_rd_addr = rp_ff;
   assign pkt_rd_en    = accept & pkt_rd;
   assign pkt_rd_addr  = ridx_addr[PA_W-1:0];
   assign pkt_wr_addr  = count_ff[PA_W-1:0];

endmodule

@@ sim/uart_rx_packetizer_checker.sv @@
// Response predictor and scoreboard for the UART receive FIFO packetizer.
`timescale 1ns / 1ps

module uart_rx_packetizer_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  uifp_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  uifp_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [7:0]        csr_write_data,
   output int                failures,
   output int                pending
);

   localparam int RING_SLOTS = uifp_pkg::RING_DEPTH_DEF;
   localparam int PKT_SLOTS  = uifp_pkg::PACKET_DEPTH_DEF;

   logic [7:0] ring_mem [RING_SLOTS];
   logic [7:0] pkt_mem  [PKT_SLOTS];
   int         ring_wr;
   int         ring_rd;
   int         pkt_len;
   int         idle_count;
   logic       gathering;
   logic [7:0] idle_limit;

   uifp_pkg::rsp_type packetizer_rsp_q [$];
   int         fail_count = 0;
   int         rsp_left   = 0;

   assign failures = fail_count;
   assign pending  = rsp_left;

   function automatic int ring_fill();
      return (ring_wr - ring_rd + RING_SLOTS) % RING_SLOTS;
   endfunction

   // one request in, one response out; updates the shadow state
   function automatic uifp_pkg::rsp_type packetizer_step(uifp_pkg::req_type r);
      uifp_pkg::rsp_type rsp;
      int         nxt;
      int         i;
      logic [7:0] c;
      rsp = '0;
      case (r.cmd)
         uifp_pkg::CMD_RX_BYTE: begin
            nxt = (ring_wr + 1) % RING_SLOTS;
            if (nxt != ring_rd) begin
               ring_mem[ring_wr] = r.rx_data;
               ring_wr = nxt;
            end else begin
               rsp.status = uifp_pkg::ST_FIFO_FULL;
            end
         end
         uifp_pkg::CMD_DRAIN: begin
            if (ring_wr == ring_rd) begin
               rsp.status = uifp_pkg::ST_FIFO_EMPTY;
            end else begin
               c = ring_mem[ring_rd];
               ring_rd = (ring_rd + 1) % RING_SLOTS;
               rsp.out_byte   = c;
               rsp.byte_valid = 1'b1;
               if (pkt_len < PKT_SLOTS) begin
                  pkt_mem[pkt_len] = c;
                  pkt_len++;
               end else begin
                  rsp.status = uifp_pkg::ST_PKT_FULL;
               end
               gathering  = 1'b1;
               idle_count = 0;
            end
         end
         uifp_pkg::CMD_TICK: begin
            if (gathering && ring_wr == ring_rd) begin
               if (idle_count < int'(uifp_pkg::IDLE_TICKS_MAX)) idle_count++;
               if (idle_count >= int'(idle_limit)) begin
                  rsp.packet_done = 1'b1;
                  gathering  = 1'b0;
                  idle_count = 0;
               end
            end
         end
         uifp_pkg::CMD_READ: begin
            if (int'(r.read_index) < PKT_SLOTS) begin
               rsp.out_byte   = pkt_mem[r.read_index];
               rsp.byte_valid = 1'b1;
            end
         end
         uifp_pkg::CMD_CLEAR: begin
            for (i = 0; i < pkt_len && i < PKT_SLOTS; i++) pkt_mem[i] = uifp_pkg::BYTE_ZERO;
            pkt_len = 0;
         end
         default: ;
      endcase
      rsp.packet_length = pkt_len[7:0];
      rsp.fetch_active  = gathering;
      rsp.fifo_count    = 6'(ring_fill());
      return rsp;
   endfunction

   function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      uifp_pkg::rsp_type want;
      int      i;
      if (reset) begin
         for (i = 0; i < RING_SLOTS; i++) ring_mem[i] = uifp_pkg::BYTE_ZERO;
         for (i = 0; i < PKT_SLOTS; i++) pkt_mem[i] = uifp_pkg::BYTE_ZERO;
         ring_wr    = 0;
         ring_rd    = 0;
         pkt_len    = 0;
         idle_count = 0;
         gathering  = 1'b0;
         idle_limit = uifp_pkg::IDLE_LIMIT_RESET;
         packetizer_rsp_q.delete();
      end else begin
         if (csr_write_enable) idle_limit = csr_write_data;
         if (rsp_valid && !rsp_stall) begin
            if (packetizer_rsp_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response, expected none actual %p", $time, rsp_data);
            end else begin
               want = packetizer_rsp_q.pop_front();
               check_field("out_byte", want.out_byte, rsp_data.out_byte);
               check_field("byte_valid", want.byte_valid, rsp_data.byte_valid);
               check_field("status", want.status, rsp_data.status);
               check_field("packet_length", want.packet_length, rsp_data.packet_length);
               check_field("packet_done", want.packet_done, rsp_data.packet_done);
               check_field("fetch_active", want.fetch_active, rsp_data.fetch_active);
               check_field("fifo_count", want.fifo_count, rsp_data.fifo_count);
            end
         end
         if (req_valid && !req_stall) packetizer_rsp_q.push_back(packetizer_step(req_data));
      end
      rsp_left = packetizer_rsp_q.size();
   end

endmodule

@@ sim/testbench.sv @@
// Stimulus, idling control and verdict for the UART receive FIFO packetizer.
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT = 200000;
   localparam int ROUNDS      = 6;
   localparam int ROUND_ITEMS = 140;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   uifp_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   uifp_pkg::rsp_type rsp_data;
   logic              csr_write_enable;
   logic [7:0]        csr_write_data;
   int                failures;
   int                pending;

   // idling knobs, shared between the sender (main process) and the receiver
   int         send_idle_pct;
   int         rsp_idle_pct;
   int         hold_off_cycles;
   int         requests_sent;
   int         cycle_count;
   logic [7:0] limit_now;

   uart_rx_fifo_idle_packetizer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // watches both channels and the register port, predicts and scores
   uart_rx_packetizer_checker scoreboard (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .failures         (failures),
      .pending          (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   // Receiver: stall is driven on the falling edge. A pending hold-off wins over
   // the random stall and is counted down here, once per falling edge.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_off_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   // Offer one request. Random idle cycles go in front of it; valid stays up
   // from the previous request when no idle cycle is drawn, so back-to-back
   // requests never see valid dropped and raised in one step. Returns at the
   // rising edge that accepted the request.
   task automatic send_request(input logic [2:0] cmd, input logic [7:0] rx,
                               input logic [6:0] idx);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_data.cmd       <= cmd;
      req_data.rx_data   <= rx;
      req_data.read_index <= idx;
      do @(posedge clock); while (req_stall);
      requests_sent++;
   endtask

   // stop offering and wait until every predicted response has come back;
   // each request yields exactly one response, so nothing is left in flight
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // register writes only happen with the block idle
   task automatic write_idle_limit(input logic [7:0] value);
      settle_block();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      limit_now = value;
   endtask

   // knobs change just after a rising edge, away from the falling-edge readers
   task automatic set_idling(input int send_pct, input int rsp_pct);
      @(posedge clock);
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
   endtask

   // One burst of random traffic. Mostly whole packets (bytes in, drained,
   // idle ticks to close, a few reads, now and then a clear); clears are rare
   // so the packet store fills up. Big bursts can overflow the ring. The rest is
   // interleaved ring traffic and plain noise, including the unused commands.
   task automatic random_traffic();
      int kind;
      int n;
      int ticks;
      int reads;
      int i;
      kind = $urandom_range(99);
      if (kind < 65) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 12);
         for (i = 0; i < n; i++)
            send_request(uifp_pkg::CMD_RX_BYTE, 8'($urandom_range(255)),
                         7'($urandom_range(127)));
         n = n + $urandom_range(1);
         for (i = 0; i < n; i++)
            send_request(uifp_pkg::CMD_DRAIN, 8'($urandom_range(255)),
                         7'($urandom_range(127)));
         ticks = (limit_now > 12) ? $urandom_range(12) : $urandom_range(limit_now + 2);
         for (i = 0; i < ticks; i++)
            send_request(uifp_pkg::CMD_TICK, 8'($urandom_range(255)),
                         7'($urandom_range(127)));
         reads = $urandom_range(3);
         for (i = 0; i < reads; i++)
            send_request(uifp_pkg::CMD_READ, 8'($urandom_range(255)),
                         7'($urandom_range(127)));
         if ($urandom_range(99) < 8)
            send_request(uifp_pkg::CMD_CLEAR, 8'($urandom_range(255)),
                         7'($urandom_range(127)));
      end else if (kind < 82) begin
         for (i = 0; i < 8; i++)
            send_request(3'($urandom_range(uifp_pkg::CMD_TICK)), 8'($urandom_range(255)),
                         7'($urandom_range(127)));
      end else begin
         for (i = 0; i < 6; i++)
            send_request(3'($urandom_range(7)), 8'($urandom_range(255)),
                         7'($urandom_range(127)));
      end
   endtask

   initial begin
      int         round;
      int         start_count;
      int         i;
      logic [7:0] round_limit;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      send_idle_pct    = 11;
      rsp_idle_pct     = 45;
      hold_off_cycles  = 0;
      requests_sent    = 0;
      limit_now        = uifp_pkg::IDLE_LIMIT_RESET;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, idle limit at its reset value.
      send_request(uifp_pkg::CMD_DRAIN, 8'h00, 7'd0);     // drain with the ring empty
      send_request(uifp_pkg::CMD_TICK, 8'h00, 7'd0);      // tick with no packet open
      send_request(uifp_pkg::CMD_READ, 8'h00, 7'd0);      // store is empty after reset, reads zero
      send_request(uifp_pkg::CMD_READ, 8'hFF, 7'd127);    // last store slot
      send_request(uifp_pkg::CMD_RX_BYTE, 8'h00, 7'd0);
      send_request(uifp_pkg::CMD_RX_BYTE, 8'hFF, 7'd127);
      send_request(uifp_pkg::CMD_RX_BYTE, 8'hA5, 7'd0);
      send_request(uifp_pkg::CMD_TICK, 8'h00, 7'd0);      // bytes waiting, not gathering
      for (i = 0; i < 3; i++) send_request(uifp_pkg::CMD_DRAIN, 8'h00, 7'd0);
      send_request(uifp_pkg::CMD_DRAIN, 8'h00, 7'd0);     // ring empty again
      for (i = 0; i < 5; i++) send_request(uifp_pkg::CMD_TICK, 8'h00, 7'd0);  // closes on 5th
      send_request(uifp_pkg::CMD_TICK, 8'h00, 7'd0);      // packet already closed
      send_request(uifp_pkg::CMD_READ, 8'h00, 7'd0);
      send_request(uifp_pkg::CMD_READ, 8'h00, 7'd2);
      send_request(3'd5, 8'hFF, 7'd127);        // unused commands do nothing
      send_request(3'd6, 8'h00, 7'd0);
      send_request(3'd7, 8'hFF, 7'd127);
      send_request(uifp_pkg::CMD_CLEAR, 8'h00, 7'd0);
      send_request(uifp_pkg::CMD_READ, 8'h00, 7'd1);      // cleared slot reads zero

      // Random rounds. Idling: sender 11% / receiver 45% for the first two,
      // swapped for the next two, none for the last two. Each round runs with
      // its own idle limit, the extremes and zero among them.
      for (round = 0; round < ROUNDS; round++) begin
         settle_block();
         if (round < 2) set_idling(11, 45);
         else if (round < 4) set_idling(45, 11);
         else set_idling(0, 0);
         case (round)
            0:       round_limit = 8'd1;
            1:       round_limit = 8'd255;
            2:       round_limit = 8'd0;
            3:       round_limit = 8'($urandom_range(2, 8));
            4:       round_limit = 8'd3;
            default: round_limit = 8'($urandom_range(1, 12));
         endcase
         write_idle_limit(round_limit);
         start_count = requests_sent;

         // with the largest limit, one packet sits out a full idle timeout
         if (round == 1) begin
            send_request(uifp_pkg::CMD_RX_BYTE, 8'($urandom_range(255)),
                         7'($urandom_range(127)));
            send_request(uifp_pkg::CMD_DRAIN, 8'($urandom_range(255)),
                         7'($urandom_range(127)));
            for (i = 0; i < 260; i++)
               send_request(uifp_pkg::CMD_TICK, 8'($urandom_range(255)),
                            7'($urandom_range(127)));
         end

         // long receiver hold-off while the sender keeps offering back to
         // back, so the pipeline backs up and stalls the request side
         if (round == 4) begin
            @(posedge clock);
            hold_off_cycles = 150;
         end

         while (requests_sent - start_count < ROUND_ITEMS) random_traffic();
      end

      settle_block();
      repeat (10) @(negedge clock);
      if (failures == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
